// ===== rtl/fbpa_pkg.sv =====
`default_nettype none

package fbpa_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BLOCKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_STRIDE = 1'b1;

  localparam int unsigned IDX_W    = 8;
  localparam int unsigned STRIDE_W = 16;
  localparam int unsigned OFF_W    = 24;
  localparam int unsigned ALU_W    = OFF_W + 1;
  localparam int unsigned CNT_W    = 5;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(IDX_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(OFF_W - 1);

endpackage

`default_nettype wire

// ===== rtl/fixed_block_pool_allocator_unit.sv =====
`default_nettype none
// Channel    | Ports                                          | Handshake
// request    | start, in_mode, in_free_offset                 | taken when start && !busy
// result     | out_valid, out_status, out_block_offset,       | one-cycle strobe
//            | out_blocks_in_use                              |
// config     | cfg_we, cfg_index, cfg_wdata                   | written when cfg_we
//
// Refused requests (empty or error) answer in the cycle after acceptance.
// Allocate: a stack read (S_READ), then shift-add multiplication on the shared adder (S_MUL).
// Free: restoring division on the shared adder (S_DIV), with the push in its final step.
// Reset (rst_n low, synchronous) empties the stack top and marks all stack entries
// as holding their own index; no clearing pass is needed.
// The result strobe cannot be held off; busy stays high until the result is shown.
module fixed_block_pool_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 255
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_mode,
  input  wire logic [fbpa_pkg::OFF_W-1:0]     in_free_offset,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [fbpa_pkg::OFF_W-1:0]          out_block_offset,
  output logic [7:0]                          out_blocks_in_use,
  input  wire logic                           cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fbpa_pkg::STRIDE_W-1:0]  cfg_wdata
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [7:0] MAX_B = 8'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV
  } state_t;

  state_t                           state_r;
  logic [7:0]                       top_r;
  logic [7:0]                       pool_blocks_r;
  logic [fbpa_pkg::STRIDE_W-1:0]    block_stride_r;
  logic [fbpa_pkg::OFF_W-1:0]       work_r;
  logic [fbpa_pkg::STRIDE_W-1:0]    rem_r;
  logic [7:0]                       idx_r;
  logic [fbpa_pkg::CNT_W-1:0]       cnt_r;
  logic                             out_valid_r;
  logic [1:0]                       out_status_r;
  logic [fbpa_pkg::OFF_W-1:0]       out_offset_r;
  logic [7:0]                       out_in_use_r;

  logic [7:0]                       stack_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0]            valid_r;
  logic [7:0]                       rd_data_r;
  logic                             rd_valid_r;

  logic [7:0]                       usable;
  logic [7:0]                       top_dec;
  logic [AW-1:0]                    rd_addr;
  logic [AW-1:0]                    wr_addr;
  logic                             wr_en;

  logic [fbpa_pkg::ALU_W-1:0]       alu_a;
  logic [fbpa_pkg::ALU_W-1:0]       alu_b;
  logic                             alu_sub;
  logic [fbpa_pkg::ALU_W-1:0]       alu_res;

  logic [fbpa_pkg::STRIDE_W:0]      rem_sh;
  logic                             qbit;
  logic [fbpa_pkg::STRIDE_W-1:0]    rem_nxt;
  logic [fbpa_pkg::OFF_W-1:0]       work_nxt;
  logic [fbpa_pkg::OFF_W-1:0]       acc_nxt;

  assign usable  = (pool_blocks_r > MAX_B) ? MAX_B : pool_blocks_r;
  assign top_dec = top_r - 8'd1;
  assign rd_addr = top_r[AW-1:0];
  assign wr_addr = top_dec[AW-1:0];

  // shared adder / subtractor
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    rem_sh  = {rem_r, work_r[fbpa_pkg::OFF_W-1]};
    if (state_r == S_DIV) begin
      alu_a   = fbpa_pkg::ALU_W'(rem_sh);
      alu_b   = fbpa_pkg::ALU_W'(block_stride_r);
      alu_sub = 1'b1;
    end else begin
      alu_a   = {1'b0, work_r[fbpa_pkg::OFF_W-2:0], 1'b0};
      alu_b   = idx_r[7] ? fbpa_pkg::ALU_W'(block_stride_r) : '0;
      alu_sub = 1'b0;
    end
    alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + fbpa_pkg::ALU_W'(alu_sub);
  end

  assign qbit     = ~alu_res[fbpa_pkg::ALU_W-1];
  assign rem_nxt  = qbit ? alu_res[fbpa_pkg::STRIDE_W-1:0] : rem_sh[fbpa_pkg::STRIDE_W-1:0];
  assign work_nxt = {work_r[fbpa_pkg::OFF_W-2:0], qbit};
  assign acc_nxt  = alu_res[fbpa_pkg::OFF_W-1:0];
  assign wr_en    = (state_r == S_DIV) && (cnt_r == fbpa_pkg::DIV_LAST) && (top_dec < MAX_B);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= work_nxt[7:0];
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      top_r          <= '0;
      pool_blocks_r  <= 8'd255;
      block_stride_r <= 16'd1;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          fbpa_pkg::REG_POOL_BLOCKS:  pool_blocks_r  <= cfg_wdata[7:0];
          fbpa_pkg::REG_BLOCK_STRIDE: block_stride_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cnt_r <= '0;
            if (in_mode == fbpa_pkg::MODE_ALLOC) begin
              if (top_r >= usable) begin
                out_valid_r  <= 1'b1;
                out_status_r <= fbpa_pkg::ST_EMPTY;
                out_offset_r <= '0;
                out_in_use_r <= top_r;
              end else begin
                state_r <= S_READ;
              end
            end else begin
              if (top_r == 8'd0) begin
                out_valid_r  <= 1'b1;
                out_status_r <= fbpa_pkg::ST_ERROR;
                out_offset_r <= '0;
                out_in_use_r <= top_r;
              end else begin
                work_r  <= in_free_offset;
                rem_r   <= '0;
                state_r <= S_DIV;
              end
            end
          end
        end
        S_READ: begin
          idx_r   <= rd_valid_r ? rd_data_r : top_r;
          work_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          work_r <= acc_nxt;
          idx_r  <= {idx_r[6:0], 1'b0};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == fbpa_pkg::MUL_LAST) begin
            top_r        <= top_r + 8'd1;
            out_valid_r  <= 1'b1;
            out_status_r <= fbpa_pkg::ST_OK;
            out_offset_r <= acc_nxt;
            out_in_use_r <= top_r + 8'd1;
            state_r      <= S_IDLE;
          end
        end
        S_DIV: begin
          work_r <= work_nxt;
          rem_r  <= rem_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == fbpa_pkg::DIV_LAST) begin
            top_r        <= top_dec;
            out_valid_r  <= 1'b1;
            out_status_r <= fbpa_pkg::ST_OK;
            out_offset_r <= '0;
            out_in_use_r <= top_dec;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_offset  = out_offset_r;
  assign out_blocks_in_use = out_in_use_r;

endmodule

`default_nettype wire
